@@ rtl/keyword_block_indexer_top_assert.svh @@
// Assertion macros for the keyword block indexer checker.
`ifndef KEYWORD_BLOCK_INDEXER_TOP_ASSERT_SVH
`define KEYWORD_BLOCK_INDEXER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define KBI_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyword block indexer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define KBI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyword block indexer check failed");

`endif

@@ rtl/kbi_pkg.sv @@
// Shared types, constants and the case-folding function of the keyword block indexer.
package kbi_pkg;

	localparam int NUM_KEYWORDS_DEF    = 64;
	localparam int KEYWORD_MAX_LEN_DEF = 64;
	localparam int CHUNK_LEN_DEF       = 99;

	localparam logic [7:0] LF_BYTE = 8'h0A;
	localparam logic [7:0] CR_BYTE = 8'h0D;

	typedef enum logic [1:0] {
		OP_TEXT   = 2'd0,
		OP_KW     = 2'd1,
		OP_KW_END = 2'd2,
		OP_PASS   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// One classified item as it travels from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       lf;
		logic       cr;
	} item_t;

	// Fold ASCII and KOI8-R upper case to lower case, Yo to Ye
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
		else if (c >= 8'hE0) r = c - 8'h20;
		else if (c == 8'hB3) r = 8'hC5;
		return r;
	endfunction

endpackage

@@ rtl/kbi_front.sv @@
// Front end: accepts items, folds and classifies them, and queues them for the back end.
module kbi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // byte_value[7:0]
	input  logic [1:0]    s_tuser,   // opcode[1:0]
	output logic          item_valid,
	output kbi_pkg::item_t item,
	input  logic          pop
);
	import kbi_pkg::*;

	item_t      buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	// Classify the incoming item
	always_comb begin
		cls.op   = op_t'(s_tuser);
		cls.data = fold_byte(s_tdata);
		cls.lf   = (s_tdata == LF_BYTE);
		cls.cr   = (s_tdata == CR_BYTE);
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign push       = s_tvalid && s_tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = buf_q[rd_ptr_q];

	// Store queue entries
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= cls;
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/kbi_back.sv @@
// Back end: keyword store, per-keyword match sweep, chunk and block tracking, result register.
module kbi_back #(
	parameter int NUM_KEYWORDS    = kbi_pkg::NUM_KEYWORDS_DEF,
	parameter int KEYWORD_MAX_LEN = kbi_pkg::KEYWORD_MAX_LEN_DEF,
	parameter int CHUNK_LEN       = kbi_pkg::CHUNK_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  kbi_pkg::item_t item,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata    // blk_index[31:0]
);
	import kbi_pkg::*;

	localparam int CW  = $clog2(NUM_KEYWORDS + 1);
	localparam int KIW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
	localparam int LW  = $clog2(KEYWORD_MAX_LEN + 1);
	localparam int BIW = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
	localparam int PW  = $clog2(CHUNK_LEN + 1);

	// Keyword rows, lengths and match progress
	logic [KEYWORD_MAX_LEN*8-1:0] kw_mem   [NUM_KEYWORDS];
	logic [LW-1:0]                len_mem  [NUM_KEYWORDS];
	logic [KEYWORD_MAX_LEN-1:0]   prog_mem [NUM_KEYWORDS];

	state_t             state_q, state_d;
	logic [CW-1:0]      kw_count_q;
	logic [LW-1:0]      load_pos_q;
	logic [PW-1:0]      chunk_pos_q;
	logic               blank_q;
	logic               hit_q;
	logic [31:0]        counter_q;
	logic [NUM_KEYWORDS-1:0] row_vld_q;
	logic [KIW-1:0]     idx_q;
	logic [7:0]         byte_q;
	logic               end_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	logic [KEYWORD_MAX_LEN*8-1:0] kw_rd_s1;
	logic [LW-1:0]                len_rd_s1;
	logic [KEYWORD_MAX_LEN-1:0]   prog_rd_s1;
	logic [KIW-1:0]               idx_s1;
	logic                         vld_s1;

	logic                       rd_en;
	logic                       last_row;
	logic                       fin_go;
	logic                       emit;
	logic                       room;
	logic                       kw_we;
	logic                       len_we;
	logic [KEYWORD_MAX_LEN-1:0] old_row;
	logic [KEYWORD_MAX_LEN-1:0] new_row;
	logic [LW-1:0]              len_m1;
	logic                       row_hit;

	assign room     = (kw_count_q < CW'(NUM_KEYWORDS));
	assign last_row = (CW'(idx_q) == CW'(kw_count_q - 1'b1));
	assign kw_we    = pop && item.op == OP_KW && room && load_pos_q < LW'(KEYWORD_MAX_LEN);
	assign len_we   = pop && item.op == OP_KW_END && room && load_pos_q != '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item.op == OP_TEXT)
					state_d = (kw_count_q != '0) ? ST_SWEEP : ST_FINISH;
			end
			ST_SWEEP:  if (last_row) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: if (fin_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop    = 1'b0;
		rd_en  = 1'b0;
		fin_go = 1'b0;
		unique case (state_q)
			ST_IDLE:   pop = item_valid;
			ST_SWEEP:  rd_en = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: fin_go = !(end_q && blank_q && hit_q && out_valid_q && !m_tready);
			default:   ;
		endcase
		emit = fin_go && end_q && blank_q && hit_q;
	end

	// Step the match cells of the row just read
	always_comb begin
		old_row = row_vld_q[idx_s1] ? prog_rd_s1 : '0;
		for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
			if (j == 0)
				new_row[j] = (kw_rd_s1[7:0] == byte_q);
			else
				new_row[j] = old_row[j-1] && (kw_rd_s1[8*j +: 8] == byte_q);
			if (LW'(j) >= len_rd_s1) new_row[j] = 1'b0;
		end
		len_m1  = len_rd_s1 - 1'b1;
		row_hit = new_row[len_m1[BIW-1:0]];
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (kw_we)
			kw_mem[kw_count_q[KIW-1:0]][8*load_pos_q[BIW-1:0] +: 8] <= item.data;
		if (len_we)
			len_mem[kw_count_q[KIW-1:0]] <= load_pos_q;
		if (vld_s1)
			prog_mem[idx_s1] <= new_row;
		kw_rd_s1   <= kw_mem[idx_q];
		len_rd_s1  <= len_mem[idx_q];
		prog_rd_s1 <= prog_mem[idx_q];
		idx_s1     <= idx_q;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop && item.op == OP_TEXT) begin
			byte_q <= item.data;
			end_q  <= item.lf || (chunk_pos_q == PW'(CHUNK_LEN - 1));
		end
		if (emit) out_data_q <= counter_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kw_count_q  <= '0;
			load_pos_q  <= '0;
			chunk_pos_q <= '0;
			blank_q     <= 1'b0;
			hit_q       <= 1'b0;
			counter_q   <= '0;
			row_vld_q   <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (emit)          out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (rd_en) idx_q <= idx_q + 1'b1;
			if (vld_s1) begin
				row_vld_q[idx_s1] <= 1'b1;
				if (row_hit) hit_q <= 1'b1;
			end
			if (kw_we) load_pos_q <= load_pos_q + 1'b1;
			if (pop) begin
				unique case (item.op)
					OP_TEXT: begin
						idx_q <= '0;
						if (chunk_pos_q == '0) blank_q <= item.lf || item.cr;
						chunk_pos_q <= chunk_pos_q + 1'b1;
					end
					OP_KW: ;
					OP_KW_END: begin
						if (len_we) begin
							row_vld_q[kw_count_q[KIW-1:0]] <= 1'b0;
							kw_count_q <= kw_count_q + 1'b1;
						end
						load_pos_q <= '0;
					end
					default: begin
						kw_count_q  <= '0;
						load_pos_q  <= '0;
						row_vld_q   <= '0;
						chunk_pos_q <= '0;
						blank_q     <= 1'b0;
						hit_q       <= 1'b0;
						counter_q   <= '0;
					end
				endcase
			end
			// Close the chunk, and the block if the chunk opened blank
			if (fin_go && end_q) begin
				if (blank_q) begin
					counter_q <= counter_q + 32'd1;
					hit_q     <= 1'b0;
				end
				chunk_pos_q <= '0;
				blank_q     <= 1'b0;
				row_vld_q   <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ rtl/keyword_block_indexer_top.sv @@
// Top level of the keyword block indexer.
// Input channel s_*: one item per handshake, opcode in s_tuser, byte in s_tdata.
//   Opcodes: text byte, keyword byte, end of keyword, start of a new pass.
// Output channel m_*: the number of each finished block that held a keyword.
// A two-entry queue parts the front end, which folds case and classifies,
// from the back end, which runs the match sweep.
// Keyword bytes, end of keyword and new pass are taken in the idle state.
// A text byte is taken in the idle state and then runs the sweep, drain and
// finish states (idle to finish with no keywords): the sweep reads one
// keyword row per cycle from the keyword, length and progress memories
// and writes the stepped row back; a result is registered in finish.
// Reset clears all counters, the keyword count and the match state at once; no
// clearing pass is run. While m_tready is low the result is held, and the
// back end waits only when a second result is ready; input is then held off
// through s_tready once the queue fills.
module keyword_block_indexer_top #(
	parameter int NUM_KEYWORDS    = kbi_pkg::NUM_KEYWORDS_DEF,
	parameter int KEYWORD_MAX_LEN = kbi_pkg::KEYWORD_MAX_LEN_DEF,
	parameter int CHUNK_LEN       = kbi_pkg::CHUNK_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_value[7:0]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // blk_index[31:0]
);
	import kbi_pkg::*;

	item_t item;
	logic  item_valid;
	logic  pop;

	kbi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop)
	);

	kbi_back #(
		.NUM_KEYWORDS    (NUM_KEYWORDS),
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
		.CHUNK_LEN       (CHUNK_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

@@ rtl/kbi_checker.sv @@
// Port-level checker of the keyword block indexer and its bind.
`include "keyword_block_indexer_top_assert.svh"

module kbi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,   // byte_value[7:0]
	input logic [1:0]  s_tuser,   // opcode[1:0]
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata    // blk_index[31:0]
);
	// Hold a stalled result
	`KBI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`KBI_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	// A shown result carries known bits
	`KBI_ASSERT_IMPL(a_out_known, m_tvalid, !$isunknown(m_tdata))
	// The queue takes input straight after reset
	`KBI_ASSERT_IMPL(a_ready_after_reset, !$past(arst_n), s_tready)

endmodule

bind keyword_block_indexer_top kbi_checker u_kbi_checker (.*);

@@ test/tb.sv @@
// Testbench for the keyword block indexer: directed and random item streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import kbi_pkg::*;

	localparam int NKW  = NUM_KEYWORDS_DEF;
	localparam int KLEN = KEYWORD_MAX_LEN_DEF;
	localparam int CLEN = CHUNK_LEN_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;  // byte_value[7:0]
	logic [1:0]  s_tuser = 2'd0;  // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // blk_index[31:0]

	keyword_block_indexer_top dut (.*);

	always #6 clk = ~clk;

	// Predictor state
	logic [7:0]      kw_mem [NKW][KLEN];
	int unsigned     kw_len [NKW];
	int unsigned     kw_num, load_pos, chunk_pos;
	logic [KLEN-1:0] progress [NKW];
	bit              blank_start, marked;
	logic [31:0]     blk_count;

	logic [31:0] hit_blocks [$];
	int          errors = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [7:0]  words [$];

	function automatic logic [7:0] to_lower(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
		if (c >= 8'hE0) return c - 8'h20;
		if (c == 8'hB3) return 8'hC5;
		return c;
	endfunction

	task automatic clear_search();
		for (int i = 0; i < NKW; i++) progress[i] = '0;
	endtask

	task automatic predict(op_t op, logic [7:0] raw);
		logic [7:0] c;
		int unsigned l;
		c = to_lower(raw);
		case (op)
			OP_TEXT: begin
				if (chunk_pos == 0) blank_start = (raw == LF_BYTE || raw == CR_BYTE);
				for (int i = 0; i < kw_num; i++) begin
					l = kw_len[i];
					for (int j = l - 1; j > 0; j--)
						progress[i][j] = progress[i][j-1] && kw_mem[i][j] == c;
					progress[i][0] = kw_mem[i][0] == c;
					if (progress[i][l-1]) marked = 1;
				end
				chunk_pos++;
				if (raw == LF_BYTE || chunk_pos >= CLEN) begin
					if (blank_start) begin
						if (marked) hit_blocks.push_back(blk_count);
						blk_count++;
						marked = 0;
					end
					chunk_pos = 0;
					blank_start = 0;
					clear_search();
				end
			end
			OP_KW: begin
				if (kw_num < NKW && load_pos < KLEN) begin
					kw_mem[kw_num][load_pos] = c;
					load_pos++;
				end
			end
			OP_KW_END: begin
				if (kw_num < NKW && load_pos > 0) begin
					kw_len[kw_num] = load_pos;
					progress[kw_num] = '0;
					kw_num++;
				end
				load_pos = 0;
			end
			default: begin
				kw_num = 0;
				load_pos = 0;
				chunk_pos = 0;
				blank_start = 0;
				marked = 0;
				blk_count = 0;
				clear_search();
			end
		endcase
	endtask

	// Send one item in bursts with random gaps; predict on acceptance
	task automatic send_item(op_t op, logic [7:0] b);
		while (gap_left > 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict(op, b);
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 30);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	task automatic send_keyword(logic [7:0] w [$]);
		foreach (w[i]) send_item(OP_KW, w[i]);
		send_item(OP_KW_END, 8'd0);
	endtask

	task automatic send_text(logic [7:0] t [$]);
		foreach (t[i]) send_item(OP_TEXT, t[i]);
	endtask

	// Receiver stalls on its own pattern, with quiet stretches
	always @(posedge clk) begin
		if (($urandom_range(0, 255) < 64)) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Compare each accepted result with the oldest expected block number
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_blocks.size() == 0) begin
				$error("unexpected result blk_index=%0d", m_tdata);
				errors++;
			end else begin
				if (m_tdata !== hit_blocks[0]) begin
					$error("blk_index expected %0d actual %0d", hit_blocks[0], m_tdata);
					errors++;
				end
				void'(hit_blocks.pop_front());
			end
		end
	end

	task automatic test_directed();
		logic [7:0] t [$];
		// Mixed case ASCII and KOI8-R, Yo folding, zero byte
		send_keyword('{8'h41, 8'h62});
		send_keyword('{8'hE1, 8'hB3});
		send_keyword('{8'h00, 8'hFF});
		send_item(OP_KW_END, 8'd0);  // empty keyword
		send_text('{8'h0A, 8'h61, 8'h42, 8'h0A});
		send_text('{8'h0D, 8'hC1, 8'hC5, 8'h0A});
		send_text('{8'h0A, 8'h00, 8'hDF, 8'hA3, 8'h0A});
		send_text('{8'h0A});
		// Keyword longer than the limit
		t = {};
		for (int i = 0; i < KLEN + 3; i++) t.push_back(8'h7A);
		send_keyword(t);
		// Chunk cut by length, then a new pass
		t = {};
		for (int i = 0; i < CLEN; i++) t.push_back(i == 0 ? 8'h0D : 8'h7A);
		send_text(t);
		send_item(OP_PASS, 8'hFF);
		send_text('{8'h0A, 8'h0A});
	endtask

	task automatic test_overflow();
		send_item(OP_PASS, 8'd0);
		for (int k = 0; k < NKW + 2; k++) send_keyword('{8'h71, 8'(k)});
		send_text('{8'h0A, 8'h71, 8'h05, 8'h0A, 8'h0A});
	endtask

	task automatic random_byte(output logic [7:0] b);
		if ($urandom_range(0, 3) == 0) b = 8'($urandom);
		else if (words.size() > 0 && $urandom_range(0, 2) == 0)
			b = words[$urandom_range(0, words.size() - 1)];
		else b = 8'($urandom_range(8'h61, 8'h64));
	endtask

	task automatic test_random();
		logic [7:0] b;
		logic [7:0] w [$];
		int n;
		for (int round = 0; round < 6; round++) begin
			send_item(OP_PASS, 8'($urandom));
			words = {};
			repeat ($urandom_range(1, 6)) begin
				w = {};
				n = $urandom_range(1, 3);
				repeat (n) begin
					b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(8'h41, 8'h44));
					w.push_back(b);
					words.push_back(b);
				end
				send_keyword(w);
			end
			repeat (190) begin
				case ($urandom_range(0, 19))
					0:       send_item(OP_TEXT, 8'h0D);
					1, 2, 3: send_item(OP_TEXT, LF_BYTE);
					4:       send_item(op_t'($urandom_range(1, 2)), 8'($urandom));
					default: begin
						random_byte(b);
						send_item(OP_TEXT, b);
					end
				endcase
			end
		end
	endtask

	initial begin
		ref_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random();
		s_tvalid <= 1'b0;
		while (hit_blocks.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	task automatic ref_clear();
		kw_num = 0;
		load_pos = 0;
		chunk_pos = 0;
		blank_start = 0;
		marked = 0;
		blk_count = 0;
		clear_search();
	endtask

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kbi_pkg.sv
rtl/kbi_front.sv
rtl/kbi_back.sv
rtl/keyword_block_indexer_top.sv
rtl/kbi_checker.sv
test/tb.sv
